>>> rtl/rpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants of the radix percent decoder: character codes,
// register map and the configuration bundle passed to the datapath.
// ----------------------------------------------------------------------------
package rpd_pkg;

   // Special characters of the encoded stream
   localparam logic [7:0] PERCENT_CHAR = 8'h25;
   localparam logic [7:0] MINUS_CHAR   = 8'h2d;

   // Alphabet storage: five 64-bit words, eight symbols each
   localparam int ALPHA_WORDS = 5;
   localparam int WORD_W      = 64;
   localparam int SYM_TOTAL   = ALPHA_WORDS * 8;
   localparam int ALPHA_BITS  = ALPHA_WORDS * WORD_W;

   localparam int RADIX_W       = 6;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

   // Register file: 64-bit registers at byte address 8*index
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [2:0] {
      REG_RADIX  = 3'd0,
      REG_ALPHA0 = 3'd1,
      REG_ALPHA1 = 3'd2,
      REG_ALPHA2 = 3'd3,
      REG_ALPHA3 = 3'd4,
      REG_ALPHA4 = 3'd5
   } csr_reg_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [RADIX_W-1:0]    radix;
      logic [ALPHA_BITS-1:0] alphabet;  // symbol i in bits [8*i +: 8]
   } cfg_type;

endpackage : rpd_pkg
`default_nettype wire

>>> rtl/rpd_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_csr
// Configuration register file with a 64-bit APB-style port: digit base and
// the five alphabet words.
// ----------------------------------------------------------------------------
module rpd_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [rpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [rpd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output rpd_pkg::cfg_type                      cfg
);
   import rpd_pkg::*;

   logic [RADIX_W-1:0]                  radix_ff, radix_in;
   logic [ALPHA_WORDS-1:0][WORD_W-1:0]  alpha_ff, alpha_in;
   logic                                wr_en;
   csr_reg_type                         reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);

   // Write decode
   always_comb begin
      radix_in = radix_ff;
      alpha_in = alpha_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_RADIX:  radix_in    = csr_pwdata[RADIX_W-1:0];
            REG_ALPHA0: alpha_in[0] = csr_pwdata;
            REG_ALPHA1: alpha_in[1] = csr_pwdata;
            REG_ALPHA2: alpha_in[2] = csr_pwdata;
            REG_ALPHA3: alpha_in[3] = csr_pwdata;
            REG_ALPHA4: alpha_in[4] = csr_pwdata;
            default: ;  // unmapped address, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         alpha_ff <= '0;
      end else begin
         radix_ff <= radix_in;
         alpha_ff <= alpha_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         REG_RADIX:  csr_prdata = {{(CSR_DATA_W-RADIX_W){1'b0}}, radix_ff};
         REG_ALPHA0: csr_prdata = alpha_ff[0];
         REG_ALPHA1: csr_prdata = alpha_ff[1];
         REG_ALPHA2: csr_prdata = alpha_ff[2];
         REG_ALPHA3: csr_prdata = alpha_ff[3];
         REG_ALPHA4: csr_prdata = alpha_ff[4];
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.radix    = radix_ff;
   assign cfg.alphabet = alpha_ff;

endmodule : rpd_csr
`default_nettype wire

>>> rtl/rpd_digit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_digit
// Digit lookup: compares a character against every alphabet symbol in use
// in parallel and returns the lowest matching index, or the effective radix
// when nothing matches. Also returns the effective radix itself.
// ----------------------------------------------------------------------------
module rpd_digit #(
   parameter int MAX_RADIX = 36
) (
   input  wire logic [7:0]                       char_in,
   input  wire rpd_pkg::cfg_type                 cfg,
   output logic [$clog2(MAX_RADIX+1)-1:0]        eff_radix,
   output logic [$clog2(MAX_RADIX+1)-1:0]        digit
);
   import rpd_pkg::*;

   localparam int DIG_W = $clog2(MAX_RADIX + 1);
   localparam int LANES = (MAX_RADIX < SYM_TOTAL) ? MAX_RADIX : SYM_TOTAL;

   logic [LANES-1:0] match;
   logic [LANES-1:0] first_hot;
   logic [DIG_W-1:0] hit_idx;

   // Clamp the programmed base to the number of lanes
   always_comb begin
      if (cfg.radix > RADIX_W'(LANES)) begin
         eff_radix = DIG_W'(LANES);
      end else begin
         eff_radix = DIG_W'(cfg.radix);
      end
   end

   // Per-symbol compare, only lanes below the base take part
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         match[i] = (cfg.alphabet[8*i +: 8] == char_in) && (DIG_W'(i) < eff_radix);
      end
   end

   // Keep the lowest hit and encode it
   assign first_hot = match & (~match + LANES'(1));

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < LANES; i++) begin
         if (first_hot[i]) begin
            hit_idx = hit_idx | DIG_W'(i);
         end
      end
   end

   assign digit = (|match) ? hit_idx : eff_radix;

endmodule : rpd_digit
`default_nettype wire

>>> rtl/radix_percent_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_percent_decoder_core
// Decoder for '%'-prefixed groups of digits in a programmable alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one character per item (tdata = char_in, tlast = end of
//   message). rsp_* carries one decoded byte per item (tdata = byte_out,
//   tlast = byte produced by the final character). The csr_* port sets the
//   digit base and the alphabet; write it only while no item is in flight.
//   Each character passes an input register, then lookup and multiply-add
//   into the group state and the result register, which holds its byte on
//   rsp_* until the byte is taken.
//   Throughput is one character per cycle while rsp_tready stays high,
//   limited by the single group accumulator that each character updates
//   in turn.
//   When rsp_tready is low a waiting byte holds in the result register and
//   the staged character waits behind it, whether or not it produces a byte;
//   the input takes one more character into the empty input register and
//   then stalls until the byte is taken.
//   Reset (synchronous) empties both registers, clears the group state and
//   sets the base to 10 with an all-zero alphabet.
// ----------------------------------------------------------------------------
module radix_percent_decoder_core #(
   parameter int MAX_RADIX = 36
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // character in
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] char_in
   input  wire logic                            req_tlast,   // end_of_stream
   // decoded byte out
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [7:0]                      rsp_tdata,   // [7:0] byte_out
   output logic                                 rsp_tlast,   // final_byte
   // configuration
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rpd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rpd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [rpd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import rpd_pkg::*;

   localparam int DIG_W = $clog2(MAX_RADIX + 1);

   cfg_type          cfg;
   logic [DIG_W-1:0] eff_radix;
   logic [DIG_W-1:0] digit;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   // group state
   logic       seen_ff, seen_in;
   logic [7:0] gval_ff, gval_in;
   logic       gneg_ff, gneg_in;
   logic       gnon_ff, gnon_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;

   logic        advance;
   logic        is_pct;
   logic        is_minus;
   logic [15:0] mac;
   logic [7:0]  val_upd;
   logic        neg_upd;
   logic        non_upd;
   logic        emit_pct;
   logic        emit;
   logic [7:0]  emit_byte;

   rpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rpd_digit #(
      .MAX_RADIX (MAX_RADIX)
   ) u_digit (
      .char_in   (in_char_ff),
      .cfg       (cfg),
      .eff_radix (eff_radix),
      .digit     (digit)
   );

   // Handshake: the staged item moves on unless it would overwrite a held byte
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Character step: group state after this character, before any emit
   assign is_pct   = (in_char_ff == PERCENT_CHAR);
   assign is_minus = (in_char_ff == MINUS_CHAR);
   assign mac      = 16'(gval_ff) * 16'(eff_radix) + 16'(digit);

   always_comb begin
      val_upd = gval_ff;
      neg_upd = gneg_ff;
      non_upd = gnon_ff;
      if (!is_pct) begin
         if (is_minus) begin
            neg_upd = gneg_ff | !gnon_ff;
         end else begin
            val_upd = mac[7:0];
         end
         non_upd = 1'b1;
      end
   end

   // A '%' after the message started closes the group; the last character
   // also closes a non-empty group. A '%' leaves the group untouched, so
   // both cases emit from the stepped state.
   assign emit_pct  = is_pct && seen_ff;
   assign emit      = emit_pct || (in_last_ff && non_upd);
   assign emit_byte = neg_upd ? (8'd0 - val_upd) : val_upd;

   always_comb begin
      seen_in = seen_ff;
      gval_in = gval_ff;
      gneg_in = gneg_ff;
      gnon_in = gnon_ff;
      if (advance) begin
         seen_in = seen_ff | !is_pct;
         gval_in = val_upd;
         gneg_in = neg_upd;
         gnon_in = non_upd;
         if (emit || in_last_ff) begin
            gval_in = '0;
            gneg_in = 1'b0;
            gnon_in = 1'b0;
         end
         if (in_last_ff) begin
            seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         gval_ff <= '0;
         gneg_ff <= 1'b0;
         gnon_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         gval_ff <= gval_in;
         gneg_ff <= gneg_in;
         gnon_ff <= gnon_in;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // A held byte is never dropped while the receiver stalls
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff)
      else $error("decoded byte lost under stall");

   // A non-empty group implies the message has started
   a_group_seen: assert property (@(posedge clock) disable iff (reset)
      gnon_ff |-> seen_ff)
      else $error("group open before any non-percent character");

   // The final character leaves all group state cleared
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> !seen_ff && !gnon_ff && !gneg_ff && (gval_ff == 8'd0))
      else $error("state not cleared after end of message");

   // An empty input stage always takes a new character
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stalled while empty");
`endif

endmodule : radix_percent_decoder_core
`default_nettype wire

>>> tb/radix_percent_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// radix_percent_decoder_core_tb
// Self-checking bench for the percent-group decoder. Characters go in on the
// req_ stream and decoded bytes come back on rsp_. A local decoder mirrors the
// group state and the CSR settings and queues the byte that each accepted
// character should produce; every byte taken from rsp_ is compared with the
// oldest queued one. Directed cases come first, then random messages under
// several idle/stall mixes and alphabet settings.
// ----------------------------------------------------------------------------
module radix_percent_decoder_core_tb;
   import rpd_pkg::*;

   localparam int MAX_RADIX    = 36;
   localparam int SETTLE_CYCLES = 6;     // pipeline is two deep
   localparam int QUIET_LIMIT  = 2000;   // cycles without any handshake

   typedef struct packed {
      logic [7:0] value;
      logic       final_flag;
   } decoded_byte_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;    // [7:0] char_in
   logic                  req_tlast = 1'b0;  // end_of_stream
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // [7:0] byte_out
   logic                  rsp_tlast;         // final_byte
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the register file
   logic [RADIX_W-1:0]    cfg_radix = RADIX_RESET;
   logic [ALPHA_BITS-1:0] cfg_alpha = '0;

   // Mirror of the group state
   logic                  msg_started = 1'b0;
   logic [7:0]            acc_value = '0;
   logic                  acc_negative = 1'b0;
   logic                  acc_open = 1'b0;

   decoded_byte_type      pending_bytes[$];
   int                    error_count = 0;
   int                    chars_sent = 0;
   int                    quiet_cycles = 0;
   int                    send_idle_pct = 0;
   int                    recv_stall_pct = 0;

   radix_percent_decoder_core #(.MAX_RADIX(MAX_RADIX)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder mirror
   // ------------------------------------------------------------------
   function automatic int active_base();
      return (cfg_radix > MAX_RADIX) ? MAX_RADIX : int'(cfg_radix);
   endfunction

   // Lowest matching symbol wins; no match counts as the base itself
   function automatic int symbol_index(input logic [7:0] c, input int base);
      for (int i = 0; i < base; i++)
         if (cfg_alpha[8*i +: 8] == c)
            return i;
      return base;
   endfunction

   function automatic logic [7:0] group_byte();
      return acc_negative ? 8'(-acc_value) : acc_value;
   endfunction

   function automatic void clear_group();
      acc_value    = '0;
      acc_negative = 1'b0;
      acc_open     = 1'b0;
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic last);
      int               base;
      int               acc;
      logic             emitted;
      decoded_byte_type item;
      emitted = 1'b0;
      if (c != PERCENT_CHAR) begin
         msg_started = 1'b1;
         if (c == MINUS_CHAR) begin
            // leading minus negates, any other minus is skipped
            if (!acc_open)
               acc_negative = 1'b1;
         end else begin
            base      = active_base();
            acc       = int'(acc_value) * base + symbol_index(c, base);
            acc_value = acc[7:0];
         end
         acc_open = 1'b1;
      end else if (msg_started) begin
         item.value      = group_byte();
         item.final_flag = last;
         pending_bytes.push_back(item);
         emitted = 1'b1;
         clear_group();
      end
      // end of message flushes an open group and clears everything
      if (last) begin
         if (acc_open && !emitted) begin
            item.value      = group_byte();
            item.final_flag = 1'b1;
            pending_bytes.push_back(item);
         end
         msg_started = 1'b0;
         clear_group();
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         decode_char(req_tdata, req_tlast);
   end

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      decoded_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual byte_out %02h final_byte %b",
                     $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.value) begin
               $display("%0t: byte_out mismatch, expected %02h, actual %02h",
                        $time, want.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.final_flag) begin
               $display("%0t: final_byte mismatch, expected %b, actual %b",
                        $time, want.final_flag, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Watchdog: no handshake of any kind for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      chars_sent++;
   endtask

   // Stop sending and let every queued byte and in-flight character drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      case (idx)
         REG_RADIX:  cfg_radix = value[RADIX_W-1:0];
         REG_ALPHA0: cfg_alpha[0*64 +: 64] = value;
         REG_ALPHA1: cfg_alpha[1*64 +: 64] = value;
         REG_ALPHA2: cfg_alpha[2*64 +: 64] = value;
         REG_ALPHA3: cfg_alpha[3*64 +: 64] = value;
         REG_ALPHA4: cfg_alpha[4*64 +: 64] = value;
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_alphabet(input logic [ALPHA_BITS-1:0] alpha);
      for (int w = 0; w < ALPHA_WORDS; w++)
         write_reg(csr_reg_type'(int'(REG_ALPHA0) + w), alpha[64*w +: 64]);
   endtask

   // Mostly an in-alphabet symbol, sometimes any byte at all
   function automatic logic [7:0] pick_digit();
      int base;
      base = active_base();
      if (base == 0 || $urandom_range(99) < 10)
         return 8'($urandom_range(255));
      return cfg_alpha[8*$urandom_range(base - 1) +: 8];
   endfunction

   // One well-formed message: optional extra leading '%', then groups
   task automatic send_message();
      int groups;
      int digits;
      groups = $urandom_range(1, 4);
      repeat ($urandom_range(0, 2)) send_char(PERCENT_CHAR, 1'b0);
      repeat (groups) begin
         send_char(PERCENT_CHAR, 1'b0);
         if ($urandom_range(99) < 25)
            send_char(MINUS_CHAR, 1'b0);
         digits = $urandom_range(0, 3);
         repeat (digits)
            send_char(($urandom_range(99) < 8) ? MINUS_CHAR : pick_digit(), 1'b0);
      end
      // the closing character carries the end mark
      case ($urandom_range(3))
         0:       send_char(PERCENT_CHAR, 1'b1);
         1:       send_char(MINUS_CHAR, 1'b1);
         default: send_char(pick_digit(), 1'b1);
      endcase
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: base 10, every symbol 0x00
   task automatic test_reset_settings();
      send_char(PERCENT_CHAR, 1'b0);     // ignored, nothing seen yet
      send_char(PERCENT_CHAR, 1'b0);
      send_char("A", 1'b0);              // unknown digit counts as the base
      send_char(PERCENT_CHAR, 1'b0);
      send_char(PERCENT_CHAR, 1'b0);     // empty group gives 0
      send_char(MINUS_CHAR, 1'b0);       // lone minus group
      send_char(MINUS_CHAR, 1'b0);
      send_char(PERCENT_CHAR, 1'b0);
      send_char(8'hff, 1'b1);            // end of message flushes the group
      send_char(8'h00, 1'b1);            // the one matching symbol
      wait_idle();
   endtask

   // Full 36-symbol alphabet, wrapping, negation, minus inside a group
   task automatic test_full_alphabet();
      logic [ALPHA_BITS-1:0] alpha;
      alpha = '0;
      for (int i = 0; i < 36; i++)
         alpha[8*i +: 8] = (i < 10) ? 8'(8'h30 + i) : 8'(8'h61 + i - 10);
      write_reg(REG_RADIX, 64'd36);
      write_alphabet(alpha);
      send_char(PERCENT_CHAR, 1'b0);
      send_char("z", 1'b0);
      send_char("z", 1'b0);
      send_char(PERCENT_CHAR, 1'b0);
      send_char(MINUS_CHAR, 1'b0);
      send_char("1", 1'b0);
      send_char(MINUS_CHAR, 1'b0);
      send_char("f", 1'b0);
      send_char(PERCENT_CHAR, 1'b1);     // closing '%' carries the end mark
      wait_idle();
   endtask

   // Base clamping, base one, base zero, duplicate symbols
   task automatic test_radix_extremes();
      write_reg(REG_RADIX, '1);          // 63 with junk above, clamps to 36
      send_char(PERCENT_CHAR, 1'b0);
      send_char("1", 1'b0);
      send_char("0", 1'b1);
      wait_idle();
      write_reg(REG_RADIX, 64'd1);
      send_char("0", 1'b0);
      send_char("q", 1'b0);
      send_char(PERCENT_CHAR, 1'b1);
      wait_idle();
      write_reg(REG_RADIX, 64'd0);       // nothing matches, all groups 0
      send_char("x", 1'b1);
      wait_idle();
      write_reg(REG_ALPHA0, 64'h0000_0000_0037_3735);
      write_reg(REG_RADIX, 64'd3);
      send_char("7", 1'b0);              // lowest index wins
      send_char("7", 1'b1);
      send_char(PERCENT_CHAR, 1'b1);     // end mark with nothing seen
      wait_idle();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [63:0] radix_word, input int n_chars);
      int   target;
      logic paused;
      write_reg(REG_RADIX, radix_word);
      write_alphabet({$urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom});
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target = chars_sent + n_chars;
      paused = 1'b0;
      while (chars_sent < target) begin
         if ($urandom_range(99) < 85)
            send_message();
         else
            send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
         // hold off once mid-phase until the output side is empty
         if (!paused && chars_sent >= target - n_chars / 2) begin
            wait_idle();
            paused = 1'b1;
         end
      end
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_full_alphabet();
      test_radix_extremes();
      test_random_traffic(0, 0, 64'd36, 270);
      test_random_traffic(65, 0, 64'd10, 270);
      test_random_traffic(0, 65, 64'd63, 270);
      test_random_traffic(22, 22, 64'($urandom_range(1, 63)), 270);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule : radix_percent_decoder_core_tb
